@@ rtl/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types for the LRU key/value cache: request and response payloads,
// the record handed down the cell chain and the update command.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] found_value;
    logic        evicted;
    logic [31:0] lookup_total;
    logic [31:0] miss_total;
  } rsp_t;

  // Record that ripples one cell per cycle while the key is being searched.
  typedef struct packed {
    logic        hit;
    logic [63:0] value;
  } scan_t;

  // Update command broadcast to every cell at the end of a search.
  typedef struct packed {
    logic        en;
    logic        insert;
    logic        hit;
    logic        full;
    logic [63:0] key;
    logic [63:0] value;
  } cmd_t;

endpackage

@@ rtl/lkvc_cell.sv @@
// ----------------------------------------------------------------------------
// lkvc_cell
// One cache entry: key, value, valid bit and age rank. It compares the
// broadcast key, merges its match into the search record from its upstream
// neighbor and applies the broadcast update command to its own entry.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IDX     = 0,
  localparam int unsigned RankW  = $clog2(ENTRIES),
  localparam int unsigned FillW  = $clog2(ENTRIES + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          key_i,
  input  lkvc_pkg::cmd_t       cmd_i,
  input  logic [FillW-1:0]     fill_i,
  input  logic [RankW-1:0]     hit_rank_i,
  input  lkvc_pkg::scan_t      scan_i,
  input  logic [RankW-1:0]     scan_rank_i,
  output lkvc_pkg::scan_t      scan_o,
  output logic [RankW-1:0]     scan_rank_o
);

  logic             valid_q, valid_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic [63:0]      key_q, value_q;
  logic             match;
  logic             place;
  lkvc_pkg::scan_t  scan_d;
  logic             scan_hit_q;
  logic [63:0]      scan_value_q;
  logic [RankW-1:0] scan_rank_q, scan_rank_d;

  assign match = valid_q && (key_q == key_i);

  // Keys are unique, so at most one cell matches and the first one wins.
  always_comb begin
    scan_d      = scan_i;
    scan_rank_d = scan_rank_i;
    if (!scan_i.hit && match) begin
      scan_d.hit   = 1'b1;
      scan_d.value = value_q;
      scan_rank_d  = rank_q;
    end
  end

  // A new key lands in the next free slot, or in the oldest entry when full.
  assign place = cmd_i.insert && !cmd_i.hit &&
                 (cmd_i.full ? (valid_q && rank_q == RankW'(ENTRIES - 1))
                             : (fill_i == FillW'(IDX)));

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.en) begin
      if (cmd_i.hit) begin
        if (match) begin
          rank_d = '0;
        end else if (valid_q && rank_q < hit_rank_i) begin
          rank_d = rank_q + 1'b1;
        end
      end else if (cmd_i.insert) begin
        if (place) begin
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      rank_q     <= '0;
      scan_hit_q <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      rank_q     <= rank_d;
      scan_hit_q <= scan_d.hit;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_value_q <= scan_d.value;
    scan_rank_q  <= scan_rank_d;
    if (cmd_i.en && cmd_i.insert && ((cmd_i.hit && match) || place)) begin
      value_q <= cmd_i.value;
    end
    if (cmd_i.en && place) begin
      key_q <= cmd_i.key;
    end
  end

  assign scan_o      = {scan_hit_q, scan_value_q};
  assign scan_rank_o = scan_rank_q;

endmodule

@@ rtl/lru_key_value_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key/value cache with least-recently-used replacement,
// built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy then stays high
// while the search record walks down the chain of ENTRIES cells one cell per
// clock; in the final busy cycle all cells update in parallel. The response
// shows on rsp_o for exactly one cycle with done_o high, the first cycle with
// busy low, so a new request may be issued in that same cycle. The receiver
// must take every response as it appears; there is no back-pressure.
// No clearing pass is needed after reset.
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  lkvc_pkg::req_t  req_i,
  output logic            done_o,
  output lkvc_pkg::rsp_t  rsp_o
);

  localparam int unsigned RankW = $clog2(ENTRIES);
  localparam int unsigned FillW = $clog2(ENTRIES + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic             state_q, state_d;
  logic [FillW-1:0] cnt_q, cnt_d;
  lkvc_pkg::req_t   req_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             evict_seen_q, evict_seen_d;
  logic [31:0]      lookup_cnt_q, lookup_cnt_d;
  logic [31:0]      miss_cnt_q, miss_cnt_d;
  logic             done_q;
  lkvc_pkg::rsp_t   rsp_q, rsp_d;
  logic             finish;
  logic             full;
  lkvc_pkg::cmd_t   cmd;

  lkvc_pkg::scan_t  scan   [ENTRIES+1];
  logic [RankW-1:0] scan_rk[ENTRIES+1];

  assign scan[0]    = '0;
  assign scan_rk[0] = '0;

  assign finish = (state_q == StScan) && (cnt_q == FillW'(ENTRIES));
  assign full   = (fill_q == FillW'(ENTRIES));

  assign cmd.en     = finish;
  assign cmd.insert = (req_q.req_type == lkvc_pkg::REQ_INSERT);
  assign cmd.hit    = scan[ENTRIES].hit;
  assign cmd.full   = full;
  assign cmd.key    = req_q.key;
  assign cmd.value  = req_q.value;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .key_i      (req_q.key),
      .cmd_i      (cmd),
      .fill_i     (fill_q),
      .hit_rank_i (scan_rk[ENTRIES]),
      .scan_i     (scan[i]),
      .scan_rank_i(scan_rk[i]),
      .scan_o     (scan[i+1]),
      .scan_rank_o(scan_rk[i+1])
    );
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    evict_seen_d = evict_seen_q;
    lookup_cnt_d = lookup_cnt_q;
    miss_cnt_d   = miss_cnt_q;
    rsp_d        = rsp_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StScan;
          cnt_d   = '0;
        end
      end
      StScan: begin
        cnt_d = cnt_q + 1'b1;
        if (finish) begin
          state_d = StIdle;
          rsp_d   = '0;
          if (cmd.insert) begin
            if (!cmd.hit) begin
              if (full) begin
                rsp_d.evicted = 1'b1;
                evict_seen_d  = 1'b1;
              end else begin
                fill_d = fill_q + 1'b1;
              end
            end
          end else begin
            lookup_cnt_d = lookup_cnt_q + 32'd1;
            if (cmd.hit) begin
              rsp_d.hit         = 1'b1;
              rsp_d.found_value = scan[ENTRIES].value;
            end else if (evict_seen_q) begin
              miss_cnt_d = miss_cnt_q + 32'd1;
            end
          end
          rsp_d.lookup_total = lookup_cnt_d;
          rsp_d.miss_total   = miss_cnt_d;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      fill_q       <= '0;
      evict_seen_q <= 1'b0;
      lookup_cnt_q <= '0;
      miss_cnt_q   <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      fill_q       <= fill_d;
      evict_seen_q <= evict_seen_d;
      lookup_cnt_q <= lookup_cnt_d;
      miss_cnt_q   <= miss_cnt_d;
      done_q       <= finish;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (state_q == StIdle && start) begin
      req_q <= req_i;
    end
  end

  assign busy   = (state_q == StScan);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

@@ rtl/lkvc_checker.sv @@
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks for the LRU key/value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input lkvc_pkg::rsp_t rsp_o
);

  // A search walks the whole chain, so two responses never come back to back.
  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two responses in consecutive cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("response while still busy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.hit) |-> (rsp_o.found_value == 64'd0))
    else $error("nonzero value without a hit");

  a_evict_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.evicted) |-> !rsp_o.hit)
    else $error("eviction reported together with a hit");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
